/* design/tcc_pkg.sv */
package tcc_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam int REQ_W     = 3;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;
	localparam int POS_W     = 11;
	localparam int CELL_W    = 16;

	localparam logic [CHAR_W-1:0] DEFAULT_COLOR = 8'h0F;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CODE    = 8'h20;

	localparam logic [REQ_W-1:0] REQ_PUT       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BACKSPACE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_COLOR = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic copy;
		logic fill;
		logic read_done;
		logic out_load;
	} tcc_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_read;
		logic scroll_needed;
		logic last_copy;
		logic last_fill;
	} tcc_stat_t;

endpackage

/* design/tcc_ram.sv */
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/tcc_ctrl.sv */
module tcc_ctrl import tcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  tcc_stat_t stat,
	output tcc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_COPY,
		ST_FILL
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = !((state_q == ST_IDLE) && (!out_valid || !out_stall));

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.load_req = in_valid && !in_stall;
		case (state_q)
			ST_INIT: begin
				cmd.fill = 1'b1;
				if (stat.last_fill) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.load_req) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_clear) begin
					state_d = ST_FILL;
				end else if (stat.scroll_needed) begin
					state_d = ST_COPY;
				end else if (stat.is_read) begin
					state_d = ST_READ;
				end else begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.read_done = 1'b1;
				cmd.out_load = 1'b1;
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (stat.last_copy) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (stat.last_fill) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* design/tcc_dp.sv */
module tcc_dp import tcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcc_cmd_t             cmd,
	output tcc_stat_t            stat,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [CHAR_W-1:0]    color,
	input  logic [IDX_W-1:0]     cell_index,
	output logic [ROW_OUT_W-1:0] cursor_row_out,
	output logic [COL_OUT_W-1:0] cursor_col_out,
	output logic [POS_W-1:0]     cursor_position,
	output logic [CELL_W-1:0]    cell_value,
	output logic                 scrolled
);

	logic [REQ_W-1:0]  req_q;
	logic [CHAR_W-1:0] char_q;
	logic [CHAR_W-1:0] color_req_q;
	logic [IDX_W-1:0]  idx_q;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CHAR_W-1:0] color_q;
	logic [ROW_W-1:0]  row_d;
	logic [COL_W-1:0]  col_d;
	logic [CHAR_W-1:0] color_d;
	logic              scroll_q;

	logic [ADDR_W-1:0] sweep_q;
	logic              wr_valid_s1;
	logic              wr_copy_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic [ADDR_W-1:0] pos_q;
	logic [POS_W-1:0]  pos_out;
	logic [CELL_W-1:0] blank;
	logic              newline;
	logic              bottom_row;
	logic              last_col;
	logic              wrap;
	logic              origin;
	logic              in_range;

	logic              exec_we;
	logic [ADDR_W-1:0] exec_waddr;
	logic [CELL_W-1:0] exec_wdata;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign pos_q      = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign pos_out    = POS_W'(32'(row_d) * COLUMNS + 32'(col_d));
	assign blank      = {color_q, BLANK_CODE};
	assign newline    = (char_q == NEWLINE_CODE);
	assign bottom_row = (row_q == ROW_W'(ROWS - 1));
	assign last_col   = (col_q == COL_W'(COLUMNS - 1));
	assign wrap       = newline || last_col;
	assign origin     = (row_q == '0) && (col_q == '0);
	assign in_range   = (32'(idx_q) < CELLS);

	assign stat.is_clear      = (req_q == REQ_CLEAR);
	assign stat.is_read       = (req_q == REQ_READ);
	assign stat.scroll_needed = (req_q == REQ_PUT) && wrap && bottom_row;
	assign stat.last_copy     = (sweep_q == ADDR_W'(CELLS - COLUMNS - 1));
	assign stat.last_fill     = (sweep_q == ADDR_W'(CELLS - 1));

	always_comb begin
		row_d      = row_q;
		col_d      = col_q;
		color_d    = color_q;
		exec_we    = 1'b0;
		exec_waddr = pos_q;
		exec_wdata = {color_q, char_q};
		if (cmd.exec) begin
			case (req_q)
				REQ_PUT: begin
					exec_we = !newline;
					if (wrap) begin
						col_d = '0;
						if (!bottom_row) begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
				REQ_BACKSPACE: begin
					if (!origin) begin
						exec_we    = 1'b1;
						exec_waddr = pos_q - 1'b1;
						exec_wdata = blank;
						if (col_q == '0) begin
							col_d = COL_W'(COLUMNS - 1);
							row_d = row_q - 1'b1;
						end else begin
							col_d = col_q - 1'b1;
						end
					end
				end
				REQ_CLEAR: begin
					color_d = color_req_q;
					row_d   = '0;
					col_d   = '0;
				end
				REQ_SET_COLOR: begin
					color_d = color_req_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (wr_valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = wr_copy_s1 ? mem_rdata : blank;
		end else begin
			mem_we    = exec_we;
			mem_waddr = exec_waddr;
			mem_wdata = exec_wdata;
		end
		mem_raddr = cmd.copy ? (sweep_q + ADDR_W'(COLUMNS)) : ADDR_W'(idx_q);
	end

	tcc_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			color_q     <= DEFAULT_COLOR;
			scroll_q    <= 1'b0;
			sweep_q     <= '0;
			wr_valid_s1 <= 1'b0;
		end else begin
			row_q       <= row_d;
			col_q       <= col_d;
			color_q     <= color_d;
			wr_valid_s1 <= cmd.copy || cmd.fill;
			if (cmd.exec) begin
				scroll_q <= stat.scroll_needed;
				sweep_q  <= '0;
			end else if (cmd.copy || cmd.fill) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_copy_s1 <= cmd.copy;
		wr_addr_s1 <= sweep_q;
		if (cmd.load_req) begin
			req_q       <= req_type;
			char_q      <= char_code;
			color_req_q <= color;
			idx_q       <= cell_index;
		end
		if (cmd.out_load) begin
			cursor_row_out  <= ROW_OUT_W'(row_d);
			cursor_col_out  <= COL_OUT_W'(col_d);
			cursor_position <= pos_out;
			cell_value      <= (cmd.read_done && in_range) ? mem_rdata : '0;
			scrolled        <= cmd.exec ? 1'b0 : scroll_q;
		end
	end

endmodule

/* design/text_console_cursor_scroll.sv */
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  req_type, char_code, color, cell_index
// out      output     out_valid / out_stall cursor_row_out, cursor_col_out,
//                                          cursor_position, cell_value, scrolled
//
// put char, backspace, set color: done in the exec state; read cell: exec then read state
// scroll: row copy then bottom-row blank, one cell per cycle through the single
// write port of the cell ram
// clear: every cell is blanked, one cell write per cycle
// after reset the cell ram is blanked with in_stall high
// a new request is taken while the output register is empty or being drained
module text_console_cursor_scroll import tcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [CHAR_W-1:0]    color,
	input  logic [IDX_W-1:0]     cell_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ROW_OUT_W-1:0] cursor_row_out,
	output logic [COL_OUT_W-1:0] cursor_col_out,
	output logic [POS_W-1:0]     cursor_position,
	output logic [CELL_W-1:0]    cell_value,
	output logic                 scrolled
);

	tcc_cmd_t  cmd;
	tcc_stat_t stat;

	tcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.char_code      (char_code),
		.color          (color),
		.cell_index     (cell_index),
		.cursor_row_out (cursor_row_out),
		.cursor_col_out (cursor_col_out),
		.cursor_position(cursor_position),
		.cell_value     (cell_value),
		.scrolled       (scrolled)
	);

endmodule
